/* rtl/ffba_pkg.sv */
// shared types and constants of the first-fit block allocator
// no dependencies; used by ffba_ctrl, ffba_dpath and the top level
package ffba_pkg;

  // widths of the transfer fields
  localparam int FIELD_W = 10;
  localparam int STATUS_W = 2;

  // default sizes of the heap and of the free-segment table
  localparam int HEAP_BLOCKS_DEF = 1024;
  localparam int MAX_SEGMENTS_DEF = 64;

  // a remainder this small is granted with the request
  localparam int SPLIT_MIN = 2;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTALLOC = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_CLEAR     = 4'd1,
    OP_LOAD      = 4'd2,
    OP_GRANT_RD  = 4'd3,
    OP_GRANT_CHK = 4'd4,
    OP_SCAN      = 4'd5,
    OP_DECIDE    = 4'd6,
    OP_SEG_WR    = 4'd7,
    OP_SHIFT_DN  = 4'd8,
    OP_SHIFT_UP  = 4'd9,
    OP_GRANT_WR  = 4'd10,
    OP_FAIL      = 4'd11,
    OP_OUT       = 4'd12
  } op_t;

  // command from controller to datapath
  typedef struct packed {
    op_t     op;
    status_t code;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic zero_size;
    logic null_ptr;
    logic out_of_heap;
    logic mark;
    logic scan_done;
    logic found;
    logic split;
    logic join_prev;
    logic join_next;
    logic full;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

/* rtl/ffba_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ffba_ctrl.sv */
// controller state machine of the first-fit block allocator
// depends on ffba_pkg
module ffba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ffba_pkg::sts_t sts,
  output ffba_pkg::ctl_t ctl
);
  import ffba_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_DECODE = 13'b0000000000100,
    S_GRD    = 13'b0000000001000,
    S_GCHK   = 13'b0000000010000,
    S_SCAN   = 13'b0000000100000,
    S_DECIDE = 13'b0000001000000,
    S_SEGWR  = 13'b0000010000000,
    S_SHDN   = 13'b0000100000000,
    S_SHUP   = 13'b0001000000000,
    S_GWR    = 13'b0010000000000,
    S_FAIL   = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t  state, state_next;
  status_t code, code_next;

  // state and failure code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and datapath command
  always_comb begin
    state_next = state;
    code_next  = code;
    ctl.op     = OP_NONE;
    ctl.code   = code;
    case (state)
      S_CLEAR: begin
        ctl.op = OP_CLEAR;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.is_free) begin
          if (sts.zero_size) begin
            code_next  = ST_NOFIT;
            state_next = S_FAIL;
          end else begin
            state_next = S_SCAN;
          end
        end else if (sts.null_ptr) begin
          state_next = S_DONE;
        end else if (sts.out_of_heap) begin
          code_next  = ST_NOTALLOC;
          state_next = S_FAIL;
        end else begin
          state_next = S_GRD;
        end
      end
      S_GRD: begin
        ctl.op     = OP_GRANT_RD;
        state_next = S_GCHK;
      end
      S_GCHK: begin
        ctl.op = OP_GRANT_CHK;
        if (sts.mark) begin
          state_next = S_SCAN;
        end else begin
          code_next  = ST_NOTALLOC;
          state_next = S_FAIL;
        end
      end
      S_SCAN: begin
        ctl.op = OP_SCAN;
        if (sts.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        ctl.op = OP_DECIDE;
        if (!sts.is_free) begin
          if (!sts.found) begin
            code_next  = ST_NOFIT;
            state_next = S_FAIL;
          end else if (sts.split) begin
            state_next = S_SEGWR;
          end else begin
            state_next = S_SHDN;
          end
        end else if (sts.full) begin
          code_next  = ST_FULL;
          state_next = S_FAIL;
        end else if (sts.join_prev || sts.join_next) begin
          state_next = S_SEGWR;
        end else begin
          state_next = S_SHUP;
        end
      end
      S_SEGWR: begin
        ctl.op = OP_SEG_WR;
        if (sts.is_free && sts.join_prev && sts.join_next) begin
          state_next = S_SHDN;
        end else begin
          state_next = S_GWR;
        end
      end
      S_SHDN: begin
        ctl.op = OP_SHIFT_DN;
        if (sts.shift_done) state_next = S_GWR;
      end
      S_SHUP: begin
        ctl.op = OP_SHIFT_UP;
        if (sts.shift_done) state_next = S_SEGWR;
      end
      S_GWR: begin
        ctl.op     = OP_GRANT_WR;
        state_next = S_DONE;
      end
      S_FAIL: begin
        ctl.op     = OP_FAIL;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/ffba_dpath.sv */
// datapath of the first-fit block allocator: segment table, grant table,
// scan and shift counters, result and output registers
// depends on ffba_pkg and ffba_ram
module ffba_dpath #(
  parameter int HEAP_BLOCKS = ffba_pkg::HEAP_BLOCKS_DEF,
  parameter int MAX_SEGMENTS = ffba_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ffba_pkg::ctl_t               ctl,
  output ffba_pkg::sts_t               sts,
  input  logic                         in_cmd,
  input  logic [ffba_pkg::FIELD_W-1:0] in_size,
  input  logic [ffba_pkg::FIELD_W-1:0] in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ffba_pkg::status_t            out_status,
  output logic [ffba_pkg::FIELD_W-1:0] out_block
);
  import ffba_pkg::*;

  localparam int AW = $clog2(HEAP_BLOCKS);
  localparam int LW = $clog2(HEAP_BLOCKS + 1);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int NW = (LW > FIELD_W + 1) ? LW : FIELD_W + 1;
  localparam int SEG_W = AW + LW;
  localparam int GNT_W = LW + 1;

  // request registers
  logic                cmd_r;
  logic [FIELD_W-1:0]  size_r;
  logic [FIELD_W-1:0]  hdr_r;
  logic                null_r;

  // table and walk state
  logic [CW-1:0] seg_count;
  logic [CW-1:0] idx;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;
  logic          found;
  logic [CW-1:0] pos;
  logic [AW-1:0] hit_start, prev_start, clr;
  logic [LW-1:0] hit_len, prev_len, glen;
  status_t            res_status;
  logic [FIELD_W-1:0] res_block;

  // ram ports
  logic             seg_we, seg_re, gnt_we, gnt_re;
  logic [IW-1:0]    seg_waddr, seg_raddr;
  logic [SEG_W-1:0] seg_wdata, seg_rdata;
  logic [AW-1:0]    gnt_waddr, gnt_raddr;
  logic [GNT_W-1:0] gnt_wdata, gnt_rdata;

  // derived values
  logic [NW-1:0] req, hdr_n, e_start_n, e_len_n, remain;
  logic [AW-1:0] e_start, hdr_a;
  logic [LW-1:0] e_len, alloc_len;
  logic [CW-1:0] pos_m1, idx_m1;
  logic          hit_now, issue_scan, issue_dn, issue_up, split, jp, jn;

  ffba_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
    .re(seg_re), .raddr(seg_raddr), .rdata(seg_rdata)
  );

  ffba_ram #(.WIDTH(GNT_W), .DEPTH(HEAP_BLOCKS)) u_gnt_ram (
    .clk(clk), .we(gnt_we), .waddr(gnt_waddr), .wdata(gnt_wdata),
    .re(gnt_re), .raddr(gnt_raddr), .rdata(gnt_rdata)
  );

  // field arithmetic
  assign e_start   = seg_rdata[SEG_W-1:LW];
  assign e_len     = seg_rdata[LW-1:0];
  assign e_start_n = NW'(e_start);
  assign e_len_n   = NW'(e_len);
  assign req       = NW'(size_r) + NW'(1);
  assign hdr_n     = NW'(hdr_r);
  assign hdr_a     = hdr_n[AW-1:0];
  assign remain    = NW'(hit_len) - req;
  assign split     = remain > NW'(SPLIT_MIN);
  assign alloc_len = split ? req[LW-1:0] : hit_len;
  assign pos_m1    = pos - CW'(1);
  assign idx_m1    = idx - CW'(1);
  assign jp = (pos != '0) && (NW'(prev_start) + NW'(prev_len) == hdr_n);
  assign jn = found && (hdr_n + NW'(glen) == NW'(hit_start));

  // walk conditions
  assign hit_now    = rd_vld && (cmd_r ? (e_start_n > hdr_n) : (e_len_n >= req));
  assign issue_scan = idx < seg_count;
  assign issue_dn   = idx < seg_count;
  assign issue_up   = idx > pos;

  // status to the controller
  always_comb begin
    sts.clr_done    = clr == AW'(HEAP_BLOCKS - 1);
    sts.is_free     = cmd_r;
    sts.zero_size   = size_r == '0;
    sts.null_ptr    = null_r;
    sts.out_of_heap = hdr_n >= NW'(HEAP_BLOCKS);
    sts.mark        = gnt_rdata[LW];
    sts.scan_done   = hit_now || (!rd_vld && !issue_scan);
    sts.found       = found;
    sts.split       = split;
    sts.join_prev   = jp;
    sts.join_next   = jn;
    sts.full        = !jp && !jn && (seg_count == CW'(MAX_SEGMENTS));
    sts.shift_done  = !rd_vld &&
                      !((ctl.op == OP_SHIFT_UP) ? issue_up : issue_dn);
    sts.out_free    = !out_valid || out_ready;
  end

  // ram port control
  always_comb begin
    seg_we    = 1'b0;
    seg_re    = 1'b0;
    seg_waddr = pos[IW-1:0];
    seg_raddr = idx[IW-1:0];
    seg_wdata = seg_rdata;
    gnt_we    = 1'b0;
    gnt_re    = 1'b0;
    gnt_waddr = hdr_a;
    gnt_raddr = hdr_a;
    gnt_wdata = '0;
    case (ctl.op)
      OP_CLEAR: begin
        gnt_we    = 1'b1;
        gnt_waddr = clr;
        seg_we    = clr == '0;
        seg_waddr = '0;
        seg_wdata = {AW'(0), LW'(HEAP_BLOCKS)};
      end
      OP_GRANT_RD: gnt_re = 1'b1;
      OP_SCAN:     seg_re = issue_scan;
      OP_SHIFT_DN: begin
        seg_re    = issue_dn;
        seg_we    = rd_vld;
        seg_waddr = rd_idx - IW'(1);
      end
      OP_SHIFT_UP: begin
        seg_re    = issue_up;
        seg_raddr = idx_m1[IW-1:0];
        seg_we    = rd_vld;
        seg_waddr = rd_idx + IW'(1);
      end
      OP_SEG_WR: begin
        seg_we = 1'b1;
        if (!cmd_r) begin
          seg_wdata = {AW'(NW'(hit_start) + req), remain[LW-1:0]};
        end else if (jp) begin
          seg_waddr = pos_m1[IW-1:0];
          seg_wdata = {prev_start, prev_len + glen + (jn ? hit_len : LW'(0))};
        end else if (jn) begin
          seg_wdata = {hdr_a, hit_len + glen};
        end else begin
          seg_wdata = {hdr_a, glen};
        end
      end
      OP_GRANT_WR: begin
        gnt_we = 1'b1;
        if (!cmd_r) begin
          gnt_waddr = hit_start;
          gnt_wdata = {1'b1, alloc_len};
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= CW'(1);
      clr       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.op == OP_CLEAR) clr <= clr + AW'(1);
      case (ctl.op)
        OP_LOAD, OP_DECIDE: rd_vld <= 1'b0;
        OP_SCAN:     rd_vld <= issue_scan;
        OP_SHIFT_DN: begin
          rd_vld <= issue_dn;
          if (sts.shift_done) seg_count <= seg_count - CW'(1);
        end
        OP_SHIFT_UP: begin
          rd_vld <= issue_up;
          if (sts.shift_done) seg_count <= seg_count + CW'(1);
        end
        default: ;
      endcase
      if (ctl.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        cmd_r      <= in_cmd;
        size_r     <= in_size;
        hdr_r      <= in_data - FIELD_W'(1);
        null_r     <= in_data == '0;
        idx        <= '0;
        found      <= 1'b0;
        res_status <= ST_OK;
        res_block  <= '0;
      end
      OP_GRANT_CHK: glen <= gnt_rdata[LW-1:0];
      OP_SCAN: begin
        if (issue_scan) begin
          idx    <= idx + CW'(1);
          rd_idx <= idx[IW-1:0];
        end
        if (hit_now) begin
          found     <= 1'b1;
          pos       <= CW'(rd_idx);
          hit_start <= e_start;
          hit_len   <= e_len;
        end else begin
          if (rd_vld) begin
            prev_start <= e_start;
            prev_len   <= e_len;
          end
          if (sts.scan_done) pos <= idx;
        end
      end
      OP_DECIDE: idx <= (!cmd_r || (jp && jn)) ? pos + CW'(1) : seg_count;
      OP_SHIFT_DN: begin
        if (issue_dn) begin
          idx    <= idx + CW'(1);
          rd_idx <= idx[IW-1:0];
        end
      end
      OP_SHIFT_UP: begin
        if (issue_up) begin
          idx    <= idx_m1;
          rd_idx <= idx_m1[IW-1:0];
        end
      end
      OP_GRANT_WR: begin
        if (!cmd_r) res_block <= FIELD_W'(NW'(hit_start) + NW'(1));
      end
      OP_FAIL: begin
        res_status <= ctl.code;
        res_block  <= '0;
      end
      OP_OUT: begin
        out_status <= res_status;
        out_block  <= res_block;
      end
      default: ;
    endcase
  end

  // table bounds
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    seg_count <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond table depth");

  a_remove_nonempty: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_SHIFT_DN) |-> (seg_count != '0))
    else $error("removal from an empty table");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_SHIFT_UP) |-> (seg_count < CW'(MAX_SEGMENTS)))
    else $error("insert into a full table");

endmodule

/* rtl/first_fit_block_allocator_unit.sv */
// First-fit block allocator with coalescing. One request is handled at a
// time. A request passes through fixed steps (accept, decode, grant
// lookup for a free, decide, table write, grant write, result) plus a walk
// over the table entries in the first-fit / address search and a move of
// table entries when a segment is inserted or removed. The walk and the move
// together never pass more entries than the table holds. Both run over the
// segment table ram, which reads and writes in the same cycle. After reset a
// clearing pass over all HEAP_BLOCKS grant entries wipes the allocated marks
// before the first request is taken. The result register holds one finished
// result, so a new request may be taken while it waits; a request whose
// result finds that register still full waits in its last step.
// top level; depends on ffba_pkg, ffba_ctrl, ffba_dpath and ffba_ram
module first_fit_block_allocator_unit #(
  parameter int HEAP_BLOCKS = ffba_pkg::HEAP_BLOCKS_DEF,
  parameter int MAX_SEGMENTS = ffba_pkg::MAX_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // size_blocks[9:0], data_block[19:10], zero pad
  input  logic        s_tuser,   // command: 0 allocate, 1 free
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[1:0], granted_block[11:2], zero pad
);
  import ffba_pkg::*;

  ctl_t               ctl;
  sts_t               sts;
  status_t            out_status;
  logic [FIELD_W-1:0] out_block;

  ffba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .sts(sts), .ctl(ctl)
  );

  ffba_dpath #(.HEAP_BLOCKS(HEAP_BLOCKS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_dpath (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .in_cmd(s_tuser), .in_size(s_tdata[9:0]), .in_data(s_tdata[19:10]),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_status(out_status), .out_block(out_block)
  );

  // result packing
  assign m_tdata = {4'b0000, out_block, out_status};

endmodule

/* tb/first_fit_block_allocator_unit_tb.sv */
// self-checking testbench of the first-fit block allocator: directed table, heap fragmentation, then random traffic
// depends on ffba_pkg and first_fit_block_allocator_unit; results checked against a local predictor
module first_fit_block_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffba_pkg::*;

  localparam int HEAP = 1024;
  localparam int SEGS = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  first_fit_block_allocator_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  // expected result of one request
  typedef struct packed {
    status_t    code;
    logic [9:0] block;
  } grant_res_t;

  // allocator state mirror
  int unsigned seg_base[SEGS];
  int unsigned seg_len[SEGS];
  int unsigned seg_num;
  int unsigned hdr_len[HEAP];
  bit          hdr_mark[HEAP];
  int unsigned live_blocks[$];

  grant_res_t  pending_grants[$];
  int          errors = 0;
  int          shown = 0;
  bit          sending_done = 1'b0;

  // directed rows: command, size, data block, check-against-literal, literal result
  typedef struct {
    logic       cmd;
    int unsigned size;
    int unsigned blk;
    bit         fixed;
    status_t    code;
    int unsigned block;
  } row_t;

  row_t plan[] = '{
    '{CMD_ALLOC, 0,    0,    1, ST_NOFIT,    0},   // zero size
    '{CMD_FREE,  0,    0,    1, ST_OK,       0},   // null free
    '{CMD_FREE,  0,    1023, 1, ST_NOTALLOC, 0},   // never granted
    '{CMD_ALLOC, 1023, 0,    1, ST_OK,       1},   // largest request takes the whole heap
    '{CMD_FREE,  0,    1,    1, ST_OK,       0},
    '{CMD_ALLOC, 1,    0,    1, ST_OK,       1},   // first grant
    '{CMD_ALLOC, 3,    0,    1, ST_OK,       3},
    '{CMD_FREE,  0,    1,    1, ST_OK,       0},
    '{CMD_FREE,  0,    1,    1, ST_NOTALLOC, 0},   // double free
    '{CMD_ALLOC, 1,    0,    0, ST_OK,       0},
    '{CMD_FREE,  0,    3,    0, ST_OK,       0},
    '{CMD_FREE,  0,    1,    0, ST_OK,       0},
    '{CMD_ALLOC, 1021, 0,    1, ST_OK,       1},   // small remainder taken whole
    '{CMD_ALLOC, 1,    0,    1, ST_NOFIT,    0},   // heap exhausted
    '{CMD_FREE,  0,    1,    1, ST_OK,       0},
    '{CMD_ALLOC, 1022, 0,    1, ST_OK,       1},   // whole heap
    '{CMD_FREE,  0,    2,    1, ST_NOTALLOC, 0},
    '{CMD_FREE,  0,    1,    1, ST_OK,       0}
  };

  function automatic void drop_seg(int unsigned pos);
    for (int unsigned i = pos; i + 1 < seg_num; i++) begin
      seg_base[i] = seg_base[i+1];
      seg_len[i] = seg_len[i+1];
    end
    seg_num--;
  endfunction

  // predicted outcome of one request, updating the mirror
  function automatic grant_res_t predict_grant(logic cmd, int unsigned size, int unsigned blk);
    grant_res_t r;
    int unsigned need, i, first, left, hdr, len, pos;
    bit jp, jn;
    r.code = ST_OK;
    r.block = '0;
    if (cmd == CMD_ALLOC) begin
      if (size == 0) begin
        r.code = ST_NOFIT;
        return r;
      end
      need = size + 1;
      for (i = 0; i < seg_num; i++)
        if (seg_len[i] >= need) break;
      if (i >= seg_num) begin
        r.code = ST_NOFIT;
        return r;
      end
      first = seg_base[i];
      left = seg_len[i] - need;
      if (left > SPLIT_MIN) begin
        seg_base[i] = first + need;
        seg_len[i] = left;
      end else begin
        need = seg_len[i];
        drop_seg(i);
      end
      hdr_len[first] = need;
      hdr_mark[first] = 1'b1;
      r.block = 10'(first + 1);
      return r;
    end
    if (blk == 0) return r;
    hdr = blk - 1;
    if (hdr >= HEAP || !hdr_mark[hdr]) begin
      r.code = ST_NOTALLOC;
      return r;
    end
    len = hdr_len[hdr];
    for (pos = 0; pos < seg_num; pos++)
      if (seg_base[pos] > hdr) break;
    jp = pos > 0 && seg_base[pos-1] + seg_len[pos-1] == hdr;
    jn = pos < seg_num && hdr + len == seg_base[pos];
    if (!jp && !jn && seg_num >= SEGS) begin
      r.code = ST_FULL;
      return r;
    end
    hdr_mark[hdr] = 1'b0;
    if (jp && jn) begin
      seg_len[pos-1] += len + seg_len[pos];
      drop_seg(pos);
    end else if (jp) begin
      seg_len[pos-1] += len;
    end else if (jn) begin
      seg_base[pos] = hdr;
      seg_len[pos] += len;
    end else begin
      for (i = seg_num; i > pos; i--) begin
        seg_base[i] = seg_base[i-1];
        seg_len[i] = seg_len[i-1];
      end
      seg_base[pos] = hdr;
      seg_len[pos] = len;
      seg_num++;
    end
    return r;
  endfunction

  // one request transfer in a burst; a zero gap keeps tvalid high
  task automatic send_request(logic cmd, int unsigned size, int unsigned blk,
                              bit fixed, status_t code, int unsigned block, int gap);
    grant_res_t r;
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {4'b0, blk[9:0], size[9:0]};
    do @(posedge clk); while (!s_tready);
    r = predict_grant(cmd, size, blk);
    if (fixed) begin
      r.code = code;
      r.block = 10'(block);
    end
    pending_grants.push_back(r);
    if (cmd == CMD_ALLOC && r.code == ST_OK) live_blocks.push_back(r.block);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // receiver stall pattern
  initial begin
    int phase = 0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      phase++;
      if ((phase / 300) % 3 == 0) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 99) < 60);
    end
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_grants.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result %h", m_tdata);
        end
      end else begin
        grant_res_t e;
        e = pending_grants.pop_front();
        if (m_tdata[1:0] !== e.code || m_tdata[11:2] !== e.block || m_tdata[15:12] !== 4'b0) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("mismatch: expected status %0d block %0d, got status %0d block %0d",
                     e.code, e.block, m_tdata[1:0], m_tdata[11:2]);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    int burst, pick, k;
    int unsigned sz, b;
    seg_base[0] = 0;
    seg_len[0] = HEAP;
    seg_num = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (plan[i])
      send_request(plan[i].cmd, plan[i].size, plan[i].blk, plan[i].fixed,
                   plan[i].code, plan[i].block, $urandom_range(0, 2));
    live_blocks.delete();
    // hold off until the directed part has drained
    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    // fragment the heap hard to fill the segment table
    for (k = 0; k < 140; k++)
      send_request(CMD_ALLOC, $urandom_range(1, 4), 0, 0, ST_OK, 0, 0);
    for (k = 0; k < live_blocks.size(); k += 2)
      send_request(CMD_FREE, 0, live_blocks[k], 0, ST_OK, 0, $urandom_range(0, 1));
    // random traffic
    for (k = 0; k < 650; ) begin
      burst = $urandom_range(1, 16);
      for (int j = 0; j < burst; j++, k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          sz = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 40);
          send_request(CMD_ALLOC, sz, $urandom_range(0, 1023), 0, ST_OK, 0,
                       (j == burst - 1) ? $urandom_range(1, 30) : 0);
        end else if (pick < 88 && live_blocks.size() > 0) begin
          b = $urandom_range(0, live_blocks.size() - 1);
          sz = live_blocks[b];
          live_blocks.delete(b);
          send_request(CMD_FREE, $urandom_range(0, 1023), sz, 0, ST_OK, 0,
                       (j == burst - 1) ? $urandom_range(1, 30) : 0);
        end else begin
          send_request(CMD_FREE, $urandom_range(0, 1023), $urandom_range(0, 1023), 0,
                       ST_OK, 0, (j == burst - 1) ? $urandom_range(1, 30) : 0);
        end
      end
    end
    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("first_fit_block_allocator_unit test passed");
    end else begin
      $display("first_fit_block_allocator_unit test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("first_fit_block_allocator_unit test failed");
    $finish;
  end

endmodule
